// ----- src/frns_pkg.sv -----
// Package for the fixed-radius neighbor search block.
// Holds the field widths, operation and status codes, the command and queue types
// and the back-end state type. Depends on nothing.
package frns_pkg;

   localparam int POS_W   = 16;
   localparam int IDX_W   = 6;
   localparam int CNT_W   = 7;
   localparam int FUNC_W  = 2;
   localparam int STAT_W  = 3;
   localparam int ENTRY_W = 4 * POS_W;
   localparam int QDEPTH  = 2;
   localparam int QPTR_W  = 1;

   localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_QUERY  = 2'd2;

   localparam logic REG_MAX_COUNT = 1'b0;
   localparam logic REG_MIN_COUNT = 1'b1;

   localparam logic [CNT_W-1:0] MAX_COUNT_RESET = 7'd64;
   localparam logic [CNT_W-1:0] MIN_COUNT_RESET = 7'd10;

   typedef enum logic [1:0] {
      OP_ADD,
      OP_REMOVE,
      OP_QUERY
   } op_type;

   typedef enum logic [STAT_W-1:0] {
      STAT_NEIGHBOR,
      STAT_NONE,
      STAT_ADDED,
      STAT_ADD_REFUSED,
      STAT_REMOVED,
      STAT_REMOVE_REFUSED,
      STAT_BAD_INDEX
   } status_type;

   typedef enum logic [1:0] {
      BS_IDLE,
      BS_QLOAD,
      BS_WALK,
      BS_FINISH
   } back_state_type;

   typedef struct packed {
      op_type                   op;
      logic signed [POS_W-1:0]  pos_x;
      logic signed [POS_W-1:0]  pos_y;
      logic signed [POS_W-1:0]  vel_x;
      logic signed [POS_W-1:0]  vel_y;
      logic [IDX_W-1:0]         query_index;
      logic [POS_W-1:0]         radius;
   } cmd_type;

   typedef struct packed {
      logic    push;
      cmd_type cmd;
   } q_push_type;

   typedef struct packed {
      logic valid;
      logic full;
   } q_status_type;

endpackage

// ----- src/frns_req_if.sv -----
// Request channel interface: valid/ready handshake plus the request payload.
// Depends on frns_pkg.
interface frns_req_if;
   import frns_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [FUNC_W-1:0]         func;
   logic signed [POS_W-1:0]   in_pos_x;
   logic signed [POS_W-1:0]   in_pos_y;
   logic signed [POS_W-1:0]   in_vel_x;
   logic signed [POS_W-1:0]   in_vel_y;
   logic [IDX_W-1:0]          query_index;
   logic [POS_W-1:0]          radius;

   modport source (output valid, func, in_pos_x, in_pos_y, in_vel_x, in_vel_y,
                   query_index, radius, input ready);
   modport sink   (input valid, func, in_pos_x, in_pos_y, in_vel_x, in_vel_y,
                   query_index, radius, output ready);
endinterface

// ----- src/frns_rsp_if.sv -----
// Response channel interface: valid/ready handshake plus the result payload.
// Depends on frns_pkg.
interface frns_rsp_if;
   import frns_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [STAT_W-1:0]         status;
   logic [IDX_W-1:0]          nb_index;
   logic signed [POS_W-1:0]   nb_pos_x;
   logic signed [POS_W-1:0]   nb_pos_y;
   logic signed [POS_W-1:0]   nb_vel_x;
   logic signed [POS_W-1:0]   nb_vel_y;
   logic [CNT_W-1:0]          agent_count;
   logic                      last;

   modport source (output valid, status, nb_index, nb_pos_x, nb_pos_y, nb_vel_x,
                   nb_vel_y, agent_count, last, input ready);
   modport sink   (input valid, status, nb_index, nb_pos_x, nb_pos_y, nb_vel_x,
                   nb_vel_y, agent_count, last, output ready);
endinterface

// ----- src/frns_front.sv -----
// Front end: accepts requests, decodes the function code and drops unknown codes.
// Depends on frns_pkg and frns_req_if; feeds frns_queue.
module frns_front (
   frns_req_if.sink                  req_ch,
   input  frns_pkg::q_status_type    q_stat,
   output frns_pkg::q_push_type      q_push
);
   import frns_pkg::*;

   logic   known;
   op_type op;

   always_comb begin
      known = 1'b1;
      op    = OP_ADD;
      unique case (req_ch.func)
         FUNC_ADD:    op = OP_ADD;
         FUNC_REMOVE: op = OP_REMOVE;
         FUNC_QUERY:  op = OP_QUERY;
         default:     known = 1'b0;
      endcase
   end

   assign req_ch.ready = !q_stat.full;

   always_comb begin
      q_push.push            = req_ch.valid && !q_stat.full && known;
      q_push.cmd.op          = op;
      q_push.cmd.pos_x       = req_ch.in_pos_x;
      q_push.cmd.pos_y       = req_ch.in_pos_y;
      q_push.cmd.vel_x       = req_ch.in_vel_x;
      q_push.cmd.vel_y       = req_ch.in_vel_y;
      q_push.cmd.query_index = req_ch.query_index;
      q_push.cmd.radius      = req_ch.radius;
   end

endmodule

// ----- src/frns_queue.sv -----
// Two-entry command queue between the front end and the back end.
// Depends on frns_pkg.
module frns_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  frns_pkg::q_push_type      q_push,
   input  logic                      pop,
   output frns_pkg::q_status_type    q_stat,
   output frns_pkg::cmd_type         head
);
   import frns_pkg::*;

   cmd_type             slot_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]     fill_ff, fill_in;
   logic                do_push, do_pop;

   assign q_stat.valid = (fill_ff != '0);
   assign q_stat.full  = (fill_ff == (QPTR_W+1)'(QDEPTH));
   assign head         = slot_ff[rd_ptr_ff];

   always_comb begin
      do_push   = q_push.push && !q_stat.full;
      do_pop    = pop && q_stat.valid;
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff + (QPTR_W+1)'(do_push) - (QPTR_W+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= q_push.cmd;
      end
   end

endmodule

// ----- src/frns_back.sv -----
// Back end: owns the agent table and count, executes commands, walks the table
// for queries through a read / square / compare pipeline, and drives the result register.
// Depends on frns_pkg and frns_rsp_if.
module frns_back #(
   parameter int CAPACITY = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  frns_pkg::cmd_type                   cmd,
   input  frns_pkg::q_status_type              q_stat,
   output logic                                pop,
   input  logic [frns_pkg::CNT_W-1:0]          max_count,
   input  logic [frns_pkg::CNT_W-1:0]          min_count,
   frns_rsp_if.source                          rsp_ch
);
   import frns_pkg::*;

   localparam int               AW      = $clog2(CAPACITY);
   localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
   localparam int               SQ_W    = 2 * (POS_W + 1);

   logic [ENTRY_W-1:0] mem [CAPACITY];

   back_state_type state_ff, state_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [CNT_W-1:0]         idx_ff, idx_in;
   logic signed [POS_W-1:0]  qx_ff, qx_in, qy_ff, qy_in;
   logic [2*POS_W-1:0]       rsq_ff, rsq_in;

   logic [ENTRY_W-1:0]       rd_data_ff;
   logic                     v1_ff, v1_in;
   logic [CNT_W-1:0]         idx1_ff, idx1_in;
   logic                     v2_ff, v2_in;
   logic [CNT_W-1:0]         idx2_ff, idx2_in;
   logic [ENTRY_W-1:0]       entry2_ff, entry2_in;
   logic [SQ_W-1:0]          sqx_ff, sqx_in, sqy_ff, sqy_in;
   logic                     pend_valid_ff, pend_valid_in;
   logic [CNT_W-1:0]         pend_idx_ff, pend_idx_in;
   logic [ENTRY_W-1:0]       pend_entry_ff, pend_entry_in;

   logic                     rsp_valid_ff;
   status_type               rsp_status_ff;
   logic [IDX_W-1:0]         rsp_index_ff;
   logic [ENTRY_W-1:0]       rsp_entry_ff;
   logic [CNT_W-1:0]         rsp_count_ff;
   logic                     rsp_last_ff;

   logic                     go;
   logic                     out_push;
   status_type               out_status;
   logic [CNT_W-1:0]         out_index;
   logic [ENTRY_W-1:0]       out_entry;
   logic                     out_last;

   logic                     mem_we, rd_en;
   logic [AW-1:0]            rd_addr;
   logic                     add_full, hit;
   logic signed [POS_W:0]    dx, dy;
   logic signed [SQ_W-1:0]   prod_x, prod_y;
   logic [SQ_W:0]            dsq;

   assign go = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      add_full = (count_ff >= max_count) || (count_ff >= CAP_CNT);
      dx       = {rd_data_ff[POS_W-1], rd_data_ff[POS_W-1:0]} - {qx_ff[POS_W-1], qx_ff};
      dy       = {rd_data_ff[2*POS_W-1], rd_data_ff[2*POS_W-1:POS_W]}
                 - {qy_ff[POS_W-1], qy_ff};
      prod_x   = dx * dx;
      prod_y   = dy * dy;
      dsq      = {1'b0, sqx_ff} + {1'b0, sqy_ff};
      hit      = v2_ff && (dsq <= (SQ_W+1)'(rsq_ff));
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      qx_in         = qx_ff;
      qy_in         = qy_ff;
      rsq_in        = rsq_ff;
      v1_in         = v1_ff;
      idx1_in       = idx1_ff;
      v2_in         = v2_ff;
      idx2_in       = idx2_ff;
      entry2_in     = entry2_ff;
      sqx_in        = sqx_ff;
      sqy_in        = sqy_ff;
      pend_valid_in = pend_valid_ff;
      pend_idx_in   = pend_idx_ff;
      pend_entry_in = pend_entry_ff;
      pop           = 1'b0;
      mem_we        = 1'b0;
      rd_en         = 1'b0;
      rd_addr       = idx_ff[AW-1:0];
      out_push      = 1'b0;
      out_status    = STAT_NONE;
      out_index     = '0;
      out_entry     = '0;
      out_last      = 1'b1;

      unique case (state_ff)
         BS_IDLE: begin
            if (q_stat.valid && go) begin
               unique case (cmd.op)
                  OP_ADD: begin
                     pop      = 1'b1;
                     out_push = 1'b1;
                     if (add_full) begin
                        out_status = STAT_ADD_REFUSED;
                     end else begin
                        mem_we     = 1'b1;
                        count_in   = count_ff + 1'b1;
                        out_status = STAT_ADDED;
                     end
                  end
                  OP_REMOVE: begin
                     pop      = 1'b1;
                     out_push = 1'b1;
                     if (count_ff > min_count && count_ff != '0) begin
                        count_in   = count_ff - 1'b1;
                        out_status = STAT_REMOVED;
                     end else begin
                        out_status = STAT_REMOVE_REFUSED;
                     end
                  end
                  OP_QUERY: begin
                     if ({1'b0, cmd.query_index} >= count_ff) begin
                        pop        = 1'b1;
                        out_push   = 1'b1;
                        out_status = STAT_BAD_INDEX;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = cmd.query_index[AW-1:0];
                        rsq_in   = {{POS_W{1'b0}}, cmd.radius} * {{POS_W{1'b0}}, cmd.radius};
                        state_in = BS_QLOAD;
                     end
                  end
                  default: pop = 1'b1;
               endcase
            end
         end
         BS_QLOAD: begin
            qx_in    = rd_data_ff[POS_W-1:0];
            qy_in    = rd_data_ff[2*POS_W-1:POS_W];
            idx_in   = '0;
            state_in = BS_WALK;
         end
         BS_WALK: begin
            if (go) begin
               // compare stage
               if (hit) begin
                  if (pend_valid_ff) begin
                     out_push   = 1'b1;
                     out_status = STAT_NEIGHBOR;
                     out_index  = pend_idx_ff;
                     out_entry  = pend_entry_ff;
                     out_last   = 1'b0;
                  end
                  pend_valid_in = 1'b1;
                  pend_idx_in   = idx2_ff;
                  pend_entry_in = entry2_ff;
               end
               // square stage
               v2_in     = v1_ff;
               idx2_in   = idx1_ff;
               entry2_in = rd_data_ff;
               sqx_in    = unsigned'(prod_x);
               sqy_in    = unsigned'(prod_y);
               // read stage
               if (idx_ff < count_ff) begin
                  rd_en   = 1'b1;
                  v1_in   = (idx_ff != {1'b0, cmd.query_index});
                  idx1_in = idx_ff;
                  idx_in  = idx_ff + 1'b1;
               end else begin
                  v1_in = 1'b0;
                  if (!v1_ff && !v2_ff) begin
                     state_in = BS_FINISH;
                  end
               end
            end
         end
         BS_FINISH: begin
            if (go) begin
               pop           = 1'b1;
               out_push      = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = BS_IDLE;
               if (pend_valid_ff) begin
                  out_status = STAT_NEIGHBOR;
                  out_index  = pend_idx_ff;
                  out_entry  = pend_entry_ff;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= BS_IDLE;
         count_ff      <= '0;
         v1_ff         <= 1'b0;
         v2_ff         <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         v1_ff         <= v1_in;
         v2_ff         <= v2_in;
         pend_valid_ff <= pend_valid_in;
         if (go) begin
            rsp_valid_ff <= out_push;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      qx_ff         <= qx_in;
      qy_ff         <= qy_in;
      rsq_ff        <= rsq_in;
      idx1_ff       <= idx1_in;
      idx2_ff       <= idx2_in;
      entry2_ff     <= entry2_in;
      sqx_ff        <= sqx_in;
      sqy_ff        <= sqy_in;
      pend_idx_ff   <= pend_idx_in;
      pend_entry_ff <= pend_entry_in;
      if (go && out_push) begin
         rsp_status_ff <= out_status;
         rsp_index_ff  <= out_index[IDX_W-1:0];
         rsp_entry_ff  <= out_entry;
         rsp_count_ff  <= count_in;
         rsp_last_ff   <= out_last;
      end
   end

   // agent table
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[count_ff[AW-1:0]] <= {cmd.vel_y, cmd.vel_x, cmd.pos_y, cmd.pos_x};
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.status      = rsp_status_ff;
   assign rsp_ch.nb_index    = rsp_index_ff;
   assign rsp_ch.nb_pos_x    = rsp_entry_ff[POS_W-1:0];
   assign rsp_ch.nb_pos_y    = rsp_entry_ff[2*POS_W-1:POS_W];
   assign rsp_ch.nb_vel_x    = rsp_entry_ff[3*POS_W-1:2*POS_W];
   assign rsp_ch.nb_vel_y    = rsp_entry_ff[4*POS_W-1:3*POS_W];
   assign rsp_ch.agent_count = rsp_count_ff;
   assign rsp_ch.last        = rsp_last_ff;

`ifndef NO_ASSERTIONS
   a_add_inc: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BS_IDLE && go && q_stat.valid && cmd.op == OP_ADD && !add_full)
      |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("successful add did not bump the count");

   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      (state_ff != BS_IDLE) |-> (count_ff <= CAP_CNT))
      else $error("agent count above capacity during query");

   a_walk_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BS_WALK && !go) |=> ($stable(idx_ff) && $stable(pend_valid_ff)))
      else $error("table walk advanced while the result register was blocked");

   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BS_IDLE) |-> (!pend_valid_ff && !v1_ff && !v2_ff))
      else $error("query pipeline not drained at idle");
`endif

endmodule

// ----- src/fixed_radius_neighbor_search.sv -----
// Top level of the fixed-radius neighbor search block: config registers plus
// front end, command queue and back end. Depends on frns_pkg, frns_req_if, frns_rsp_if,
// frns_front, frns_queue and frns_back.
//
//   channel   dir   handshake             carries
//   req_ch    in    valid/ready           func, new agent, query index, radius
//   rsp_ch    out   valid/ready           status, neighbor entry, count, last
//   csr_*     in    csr_we, no stall      max_count (index 0), min_count (index 1)
//
// Add and remove are done in the idle state of the back end. A query reads the query
// agent, takes a load step, reads every stored agent from the table, drains the read /
// square / compare pipeline and ends with a finish step. Every back-end step but the
// load step holds while the result register is full and not taken.
// Reset is synchronous; the table is not cleared, entries are read only below the count.
module fixed_radius_neighbor_search #(
   parameter int CAPACITY = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   frns_req_if.sink                      req_ch,
   frns_rsp_if.source                    rsp_ch,
   input  logic                          csr_we,
   input  logic                          csr_index,
   input  logic [frns_pkg::CNT_W-1:0]    csr_wdata
);
   import frns_pkg::*;

   logic [CNT_W-1:0] max_count_ff, min_count_ff;
   q_push_type       q_push;
   q_status_type     q_stat;
   cmd_type          head;
   logic             pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_count_ff <= MAX_COUNT_RESET;
         min_count_ff <= MIN_COUNT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_MAX_COUNT: max_count_ff <= csr_wdata;
            REG_MIN_COUNT: min_count_ff <= csr_wdata;
         endcase
      end
   end

   frns_front u_front (
      .req_ch (req_ch),
      .q_stat (q_stat),
      .q_push (q_push)
   );

   frns_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .q_push (q_push),
      .pop    (pop),
      .q_stat (q_stat),
      .head   (head)
   );

   frns_back #(
      .CAPACITY (CAPACITY)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd       (head),
      .q_stat    (q_stat),
      .pop       (pop),
      .max_count (max_count_ff),
      .min_count (min_count_ff),
      .rsp_ch    (rsp_ch)
   );

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps
// Testbench for fixed_radius_neighbor_search. It sends add, remove, query and
// unknown-code requests and checks each response against a table model in the bench.
// Depends on frns_pkg, frns_req_if, frns_rsp_if and the block's RTL.
module tb_top;
   import frns_pkg::*;

   localparam int TABLE_DEPTH   = 64;
   localparam int QUIET_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 80;
   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

   typedef struct packed {
      logic [FUNC_W-1:0]       func;
      logic signed [POS_W-1:0] pos_x, pos_y, vel_x, vel_y;
      logic [IDX_W-1:0]        query_index;
      logic [POS_W-1:0]        radius;
   } request_type;

   typedef struct packed {
      logic [STAT_W-1:0]       status;
      logic [IDX_W-1:0]        nb_index;
      logic signed [POS_W-1:0] pos_x, pos_y, vel_x, vel_y;
      logic [CNT_W-1:0]        agent_count;
      logic                    last;
   } response_type;

   typedef struct packed {
      logic signed [POS_W-1:0] pos_x, pos_y, vel_x, vel_y;
   } agent_type;

   logic             clock = 1'b0;
   logic             reset;
   logic             csr_we;
   logic             csr_index;
   logic [CNT_W-1:0] csr_wdata;

   frns_req_if req_ch();
   frns_rsp_if rsp_ch();

   fixed_radius_neighbor_search #(.CAPACITY(TABLE_DEPTH)) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // table model
   agent_type    agents[TABLE_DEPTH];
   int           stored = 0;
   int           max_limit;
   int           min_limit;
   response_type rsp_due_q[$];

   int errors = 0;
   int requests_sent = 0;
   int responses_seen = 0;
   int neighbors_seen = 0;
   int peak_stored = 0;
   int quiet_cycles = 0;
   bit idle_on = 1'b1;
   logic signed [POS_W-1:0] center_x = '0;
   logic signed [POS_W-1:0] center_y = '0;

   function automatic void queue_reply(response_type r);
      rsp_due_q.insert(rsp_due_q.size(), r);
   endfunction

   function automatic response_type status_reply(status_type st);
      response_type r;
      r = '0;
      r.status = st;
      r.agent_count = CNT_W'(stored);
      r.last = 1'b1;
      return r;
   endfunction

   function automatic void predict_request(request_type rq);
      response_type r;
      agent_type    anchor;
      longint       dx, dy, dsq, rsq;
      int           found;
      case (rq.func)
         FUNC_ADD: begin
            if (stored >= max_limit || stored >= TABLE_DEPTH) begin
               queue_reply(status_reply(STAT_ADD_REFUSED));
            end else begin
               agents[stored] = '{rq.pos_x, rq.pos_y, rq.vel_x, rq.vel_y};
               stored++;
               if (stored > peak_stored) peak_stored = stored;
               queue_reply(status_reply(STAT_ADDED));
            end
         end
         FUNC_REMOVE: begin
            if (stored > min_limit && stored > 0) begin
               stored--;
               queue_reply(status_reply(STAT_REMOVED));
            end else begin
               queue_reply(status_reply(STAT_REMOVE_REFUSED));
            end
         end
         FUNC_QUERY: begin
            if (rq.query_index >= stored) begin
               queue_reply(status_reply(STAT_BAD_INDEX));
            end else begin
               anchor = agents[rq.query_index];
               rsq = longint'(rq.radius) * longint'(rq.radius);
               found = 0;
               for (int i = 0; i < stored; i++) begin
                  if (i == rq.query_index) continue;
                  dx = longint'(agents[i].pos_x) - longint'(anchor.pos_x);
                  dy = longint'(agents[i].pos_y) - longint'(anchor.pos_y);
                  dsq = dx * dx + dy * dy;
                  if (dsq <= rsq) begin
                     r = '0;
                     r.status = STAT_NEIGHBOR;
                     r.nb_index = IDX_W'(i);
                     r.pos_x = agents[i].pos_x;
                     r.pos_y = agents[i].pos_y;
                     r.vel_x = agents[i].vel_x;
                     r.vel_y = agents[i].vel_y;
                     r.agent_count = CNT_W'(stored);
                     r.last = 1'b0;
                     queue_reply(r);
                     found++;
                  end
               end
               if (found == 0) queue_reply(status_reply(STAT_NONE));
               else rsp_due_q[rsp_due_q.size()-1].last = 1'b1;
            end
         end
         default: ;
      endcase
   endfunction

   function automatic request_type make_op(logic [FUNC_W-1:0] f);
      logic [95:0] noise;
      request_type rq;
      noise = {$urandom, $urandom, $urandom};
      rq = noise[$bits(request_type)-1:0];
      rq.func = f;
      return rq;
   endfunction

   function automatic request_type make_add(int x, int y, int vx, int vy);
      request_type rq;
      rq = make_op(FUNC_ADD);
      rq.pos_x = POS_W'(x);
      rq.pos_y = POS_W'(y);
      rq.vel_x = POS_W'(vx);
      rq.vel_y = POS_W'(vy);
      return rq;
   endfunction

   function automatic request_type make_query(int idx, int rad);
      request_type rq;
      rq = make_op(FUNC_QUERY);
      rq.query_index = IDX_W'(idx);
      rq.radius = POS_W'(rad);
      return rq;
   endfunction

   // mostly clustered around the current center so queries find neighbors
   function automatic request_type random_add();
      request_type rq;
      int          ox, oy;
      rq = make_op(FUNC_ADD);
      if ($urandom_range(0, 4) != 0) begin
         ox = $urandom_range(0, 3000);
         oy = $urandom_range(0, 3000);
         rq.pos_x = center_x + POS_W'(ox - 1500);
         rq.pos_y = center_y + POS_W'(oy - 1500);
      end
      return rq;
   endfunction

   function automatic request_type random_query();
      int idx, rad;
      if (stored > 0 && $urandom_range(0, 9) != 0) idx = $urandom_range(0, stored - 1);
      else idx = $urandom_range(0, TABLE_DEPTH - 1);
      case ($urandom_range(0, 9))
         0:       rad = 0;
         1, 2:    rad = $urandom_range(0, 65535);
         default: rad = $urandom_range(0, 3000);
      endcase
      return make_query(idx, rad);
   endfunction

   function automatic request_type random_request();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 35) return random_add();
      if (pick < 60) return make_op(FUNC_REMOVE);
      if (pick < 95) return random_query();
      return make_op(FUNC_UNUSED);
   endfunction

   task automatic send_request(request_type rq);
      int gap;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 11);
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.func        <= rq.func;
      req_ch.in_pos_x    <= rq.pos_x;
      req_ch.in_pos_y    <= rq.pos_y;
      req_ch.in_vel_x    <= rq.vel_x;
      req_ch.in_vel_y    <= rq.vel_y;
      req_ch.query_index <= rq.query_index;
      req_ch.radius      <= rq.radius;
      do @(posedge clock); while (!req_ch.ready);
      predict_request(rq);
      requests_sent++;
   endtask

   // unknown ops give no response, so allow a full query walk after the drain
   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      while (rsp_due_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic idx, int value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CNT_W'(value);
      @(posedge clock);
      if (idx == REG_MAX_COUNT) max_limit = value;
      else min_limit = value;
   endtask

   task automatic set_limits(int max_value, int min_value);
      wait_idle();
      csr_write(REG_MAX_COUNT, max_value);
      csr_write(REG_MIN_COUNT, min_value);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic test_directed();
      send_request(make_op(FUNC_REMOVE));
      send_request(make_query(0, 100));
      send_request(make_op(FUNC_UNUSED));
      send_request(make_add(32767, 32767, 32767, 32767));
      send_request(make_add(-32768, -32768, -32768, -32768));
      send_request(make_add(0, 0, 21845, -21846));
      send_request(make_add(0, 0, -1, 1));
      send_request(make_query(63, 65535));
      send_request(make_query(4, 0));
      send_request(make_query(2, 0));
      send_request(make_query(0, 65535));
      send_request(make_query(1, 65535));
      send_request(make_query(0, 0));
      send_request(make_query(3, 1));
      send_request(make_op(FUNC_REMOVE));
      send_request(make_op(FUNC_UNUSED));
      // radius exactly on the distance boundary
      send_request(make_add(3, 4, 256, -256));
      send_request(make_query(2, 5));
      send_request(make_query(2, 4));
      send_request(make_query(4, 5));
      send_request(make_add(-3, -4, 0, 0));
      send_request(make_query(5, 10));
   endtask

   task automatic test_limit_registers();
      set_limits(0, 127);
      send_request(random_add());
      send_request(make_op(FUNC_REMOVE));
      send_request(make_query(0, 65535));
      set_limits(8, 5);
      repeat (3) send_request(random_add());
      repeat (4) send_request(make_op(FUNC_REMOVE));
   endtask

   task automatic test_full_table();
      set_limits(127, 0);
      center_x = POS_W'($urandom);
      center_y = POS_W'($urandom);
      while (stored < TABLE_DEPTH) send_request(random_add());
      repeat (2) send_request(random_add());
      repeat (10) send_request(random_query());
      send_request(make_query(TABLE_DEPTH - 1, 65535));
      send_request(make_query(0, 0));
   endtask

   task automatic test_random_mix();
      for (int phase = 0; phase < 3; phase++) begin
         if (phase == 0) set_limits(64, 0);
         else set_limits($urandom_range(1, 64), $urandom_range(0, 64));
         idle_on = (phase != 1);
         center_x = POS_W'($urandom);
         center_y = POS_W'($urandom);
         repeat (40) send_request(random_request());
      end
   endtask

   task automatic test_steady_stream();
      idle_on = 1'b0;
      repeat (30) send_request(random_request());
   endtask

   function automatic void check_field(string name, logic [POS_W-1:0] exp_v,
                                       logic [POS_W-1:0] act_v);
      if (exp_v !== act_v) begin
         errors++;
         $display("%0t ERROR %s: expected %h, actual %h", $time, name, exp_v, act_v);
      end
   endfunction

   always @(posedge clock) begin
      response_type exp_r;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         responses_seen++;
         if (rsp_due_q.size() == 0) begin
            errors++;
            $display("%0t ERROR unexpected response: expected nothing, actual status %0d",
                     $time, rsp_ch.status);
         end else begin
            exp_r = rsp_due_q.pop_front();
            if (exp_r.status == STAT_NEIGHBOR) neighbors_seen++;
            check_field("status", POS_W'(exp_r.status), POS_W'(rsp_ch.status));
            check_field("nb_index", POS_W'(exp_r.nb_index), POS_W'(rsp_ch.nb_index));
            check_field("nb_pos_x", exp_r.pos_x, rsp_ch.nb_pos_x);
            check_field("nb_pos_y", exp_r.pos_y, rsp_ch.nb_pos_y);
            check_field("nb_vel_x", exp_r.vel_x, rsp_ch.nb_vel_x);
            check_field("nb_vel_y", exp_r.vel_y, rsp_ch.nb_vel_y);
            check_field("agent_count", POS_W'(exp_r.agent_count),
                        POS_W'(rsp_ch.agent_count));
            check_field("last", POS_W'(exp_r.last), POS_W'(rsp_ch.last));
         end
      end
   end

   initial begin
      rsp_ch.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         @(posedge clock);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t ERROR no request or response moved for %0d cycles, %0d responses pending",
                  $time, quiet_cycles, rsp_due_q.size());
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      reset              <= 1'b1;
      csr_we             <= 1'b0;
      csr_index          <= REG_MAX_COUNT;
      csr_wdata          <= '0;
      req_ch.valid       <= 1'b0;
      req_ch.func        <= FUNC_ADD;
      req_ch.in_pos_x    <= '0;
      req_ch.in_pos_y    <= '0;
      req_ch.in_vel_x    <= '0;
      req_ch.in_vel_y    <= '0;
      req_ch.query_index <= '0;
      req_ch.radius      <= '0;
      max_limit = MAX_COUNT_RESET;
      min_limit = MIN_COUNT_RESET;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_limit_registers();
      test_full_table();
      test_random_mix();
      test_steady_stream();
      wait_idle();

      $display("Sent %0d requests, checked %0d responses (%0d neighbor reports), peak fill %0d",
               requests_sent, responses_seen, neighbors_seen, peak_stored);
      $display("Limits went through max_count 0..127 and min_count 0..127, full and empty table");
      if (errors == 0 && rsp_due_q.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
src/frns_pkg.sv
src/frns_req_if.sv
src/frns_rsp_if.sv
src/frns_front.sv
src/frns_queue.sv
src/frns_back.sv
src/fixed_radius_neighbor_search.sv
verif/tb_top.sv
